// File: hdl/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Types, codes and character constants shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int TW       = 20;
	localparam int QDEPTH   = 4;
	localparam int QAW      = $clog2(QDEPTH);
	localparam logic [TW-1:0] LINE_MAX = '1;

	localparam logic IN_DATA = 1'b0;
	localparam logic IN_END  = 1'b1;

	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_STRING,
		MODE_CHAR,
		MODE_LINE,
		MODE_BLOCK
	} mode_t;

	typedef enum logic [3:0] {
		TK_NEWLINE,
		TK_IDENT,
		TK_NUMBER,
		TK_STRING,
		TK_CHAR,
		TK_AT,
		TK_SYMBOL,
		TK_END,
		TK_ERROR
	} tkind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_BLOCK,
		ERR_LITERAL
	} err_t;

	typedef struct packed {
		tkind_t          kind;
		logic [TW-1:0]   offset;
		logic [TW-1:0]   length;
		logic [TW-1:0]   line;
		logic [7:0]      first;
		err_t            err;
	} tok_t;

	typedef struct packed {
		tok_t tok;
		logic last;
	} entry_t;

	function automatic tok_t mk_tok(tkind_t k, logic [TW-1:0] off, logic [TW-1:0] len,
			logic [TW-1:0] ln, logic [7:0] fb, err_t e);
		tok_t t;
		t.kind   = k;
		t.offset = off;
		t.length = len;
		t.line   = ln;
		t.first  = fb;
		t.err    = e;
		return t;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

endpackage

// File: hdl/stt_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer scan core
// Holds the scan state and turns one byte or end marker into up to two tokens.
// ----------------------------------------------------------------------------
module stt_scan #(
	parameter int OFFSET_BITS = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic            is_end,
	input  logic [7:0]      data,
	output logic [1:0]      push_n,
	output stt_pkg::entry_t ent0,
	output stt_pkg::entry_t ent1
);
	import stt_pkg::*;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	mode_t                  mode_q, mode_d;
	logic                   slash_q, slash_d;
	logic                   cr_q, cr_d;
	logic                   star_q, star_d;
	logic                   esc_q, esc_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [TW-1:0]          line_q, line_d;
	logic [7:0]             lead_q, lead_d;

	tok_t                   res [2];
	logic [1:0]             n;
	logic                   do_idle;
	logic                   cont;
	logic [7:0]             delim;
	err_t                   err;
	logic [OFFSET_BITS-1:0] endp;

	always_comb begin
		mode_d  = mode_q;
		slash_d = slash_q;
		cr_d    = cr_q;
		star_d  = star_q;
		esc_d   = esc_q;
		start_d = start_q;
		pos_d   = pos_q;
		line_d  = line_q;
		lead_d  = lead_q;
		res[0]  = '0;
		res[1]  = '0;
		n       = 2'd0;
		do_idle = 1'b0;
		cont    = 1'b0;
		err     = ERR_NONE;
		delim   = (mode_q == MODE_STRING) ? CH_DQUOTE : CH_SQUOTE;
		endp    = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
		if (fire && is_end) begin
			unique case (mode_q)
				MODE_IDENT, MODE_NUMBER: begin
					res[n[0]] = mk_tok((mode_q == MODE_IDENT) ? TK_IDENT : TK_NUMBER,
						TW'(start_q), TW'(pos_q - start_q), line_d, lead_q, ERR_NONE);
					n = n + 2'd1;
				end
				MODE_STRING, MODE_CHAR: err = ERR_LITERAL;
				MODE_BLOCK: err = ERR_BLOCK;
				MODE_LINE: ;
				default: begin
					if (cr_q) begin
						res[n[0]] = mk_tok(TK_NEWLINE, TW'(start_q), TW'(1), line_d, CH_CR,
							ERR_NONE);
						n = n + 2'd1;
						if (line_d != LINE_MAX)
							line_d = line_d + 1'b1;
					end else if (slash_q) begin
						res[n[0]] = mk_tok(TK_SYMBOL, TW'(start_q), TW'(1), line_d, CH_SLASH,
							ERR_NONE);
						n = n + 2'd1;
					end
				end
			endcase
			if (err != ERR_NONE)
				res[n[0]] = mk_tok(TK_ERROR, TW'(start_q), TW'(pos_q - start_q), line_d,
					lead_q, err);
			else
				res[n[0]] = mk_tok(TK_END, TW'(pos_q), '0, line_d, CH_NUL, ERR_NONE);
			n       = n + 2'd1;
			mode_d  = MODE_IDLE;
			slash_d = 1'b0;
			cr_d    = 1'b0;
			star_d  = 1'b0;
			esc_d   = 1'b0;
			start_d = '0;
			pos_d   = '0;
			line_d  = TW'(1);
			lead_d  = '0;
		end else if (fire) begin
			unique case (mode_q)
				MODE_IDENT, MODE_NUMBER: begin
					cont = is_alpha(data) || is_digit(data) || data == CH_USCORE ||
						(mode_q == MODE_NUMBER && data == CH_DOT);
					if (!cont) begin
						res[n[0]] = mk_tok((mode_q == MODE_IDENT) ? TK_IDENT : TK_NUMBER,
							TW'(start_q), TW'(pos_q - start_q), line_d, lead_q, ERR_NONE);
						n       = n + 2'd1;
						mode_d  = MODE_IDLE;
						do_idle = 1'b1;
					end
				end
				MODE_STRING, MODE_CHAR: begin
					if (esc_q) begin
						esc_d = 1'b0;
					end else if (data == delim) begin
						res[n[0]] = mk_tok((mode_q == MODE_STRING) ? TK_STRING : TK_CHAR,
							TW'(start_q), TW'(endp - start_q), line_d, lead_q, ERR_NONE);
						n      = n + 2'd1;
						mode_d = MODE_IDLE;
					end else if (data == CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (data == CH_LF) begin
						if (line_d != LINE_MAX)
							line_d = line_d + 1'b1;
					end
				end
				MODE_LINE: begin
					if (data == CH_LF) begin
						mode_d  = MODE_IDLE;
						do_idle = 1'b1;
					end
				end
				MODE_BLOCK: begin
					if (star_q && data == CH_SLASH) begin
						mode_d = MODE_IDLE;
						star_d = 1'b0;
					end else begin
						if (data == CH_LF && line_d != LINE_MAX)
							line_d = line_d + 1'b1;
						star_d = (data == CH_STAR);
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					if (cr_q) begin
						cr_d = 1'b0;
						res[n[0]] = mk_tok(TK_NEWLINE, TW'(start_q),
							(data == CH_LF) ? TW'(2) : TW'(1), line_d, CH_CR, ERR_NONE);
						n = n + 2'd1;
						if (line_d != LINE_MAX)
							line_d = line_d + 1'b1;
						do_idle = (data != CH_LF);
					end else if (slash_q) begin
						slash_d = 1'b0;
						if (data == CH_SLASH) begin
							mode_d = MODE_LINE;
						end else if (data == CH_STAR) begin
							mode_d = MODE_BLOCK;
							star_d = 1'b0;
							lead_d = CH_SLASH;
						end else begin
							res[n[0]] = mk_tok(TK_SYMBOL, TW'(start_q), TW'(1), line_d,
								CH_SLASH, ERR_NONE);
							n       = n + 2'd1;
							do_idle = 1'b1;
						end
					end else begin
						do_idle = 1'b1;
					end
				end
			endcase
			if (do_idle) begin
				priority if (data == CH_SPACE || data == CH_TAB || data == CH_FF ||
						data == CH_VT) begin
				end else if (data == CH_LF) begin
					res[n[0]] = mk_tok(TK_NEWLINE, TW'(pos_q), TW'(1), line_d, data, ERR_NONE);
					n = n + 2'd1;
					if (line_d != LINE_MAX)
						line_d = line_d + 1'b1;
				end else if (data == CH_CR) begin
					cr_d    = 1'b1;
					start_d = pos_q;
				end else if (data == CH_SLASH) begin
					slash_d = 1'b1;
					start_d = pos_q;
				end else if (data == CH_AT) begin
					res[n[0]] = mk_tok(TK_AT, TW'(pos_q), TW'(1), line_d, data, ERR_NONE);
					n = n + 2'd1;
				end else if (is_alpha(data) || data == CH_USCORE) begin
					mode_d  = MODE_IDENT;
					start_d = pos_q;
					lead_d  = data;
				end else if (is_digit(data)) begin
					mode_d  = MODE_NUMBER;
					start_d = pos_q;
					lead_d  = data;
				end else if (data == CH_DQUOTE || data == CH_SQUOTE) begin
					mode_d  = (data == CH_DQUOTE) ? MODE_STRING : MODE_CHAR;
					start_d = pos_q;
					lead_d  = data;
					esc_d   = 1'b0;
				end else begin
					res[n[0]] = mk_tok(TK_SYMBOL, TW'(pos_q), TW'(1), line_d, data, ERR_NONE);
					n = n + 2'd1;
				end
			end
			if (pos_q != POS_MAX)
				pos_d = pos_q + 1'b1;
		end
	end

	always_comb begin
		push_n        = n;
		ent0.tok      = res[0];
		ent0.last     = (n == 2'd1);
		ent1.tok      = res[1];
		ent1.last     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			slash_q <= 1'b0;
			cr_q    <= 1'b0;
			star_q  <= 1'b0;
			esc_q   <= 1'b0;
			start_q <= '0;
			pos_q   <= '0;
			line_q  <= TW'(1);
			lead_q  <= '0;
		end else begin
			mode_q  <= mode_d;
			slash_q <= slash_d;
			cr_q    <= cr_d;
			star_q  <= star_d;
			esc_q   <= esc_d;
			start_q <= start_d;
			pos_q   <= pos_d;
			line_q  <= line_d;
			lead_q  <= lead_d;
		end
	end

`ifndef SYNTHESIS
	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_end |-> n != 2'd0)
		else $error("end marker produced no token");
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_end |=> mode_q == MODE_IDLE && line_q == TW'(1) && pos_q == '0)
		else $error("scan state not cleared after end marker");
	a_pend_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cr_q && slash_q))
		else $error("carriage return and slash pending together");
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cr_q || slash_q) |-> mode_q == MODE_IDLE)
		else $error("pending byte outside idle mode");
`endif

endmodule

// File: hdl/stt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Small register queue: takes up to two tokens per cycle, hands out one.
// ----------------------------------------------------------------------------
module stt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_n,
	input  stt_pkg::entry_t wdata0,
	input  stt_pkg::entry_t wdata1,
	input  logic            pop,
	output logic            not_empty,
	output logic            room,
	output stt_pkg::entry_t rdata
);
	import stt_pkg::*;

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   count_q;
	logic [QAW-1:0] wr_next;

	assign wr_next   = wr_q + 1'b1;
	assign not_empty = (count_q != '0);
	assign room      = (count_q <= (QAW+1)'(QDEPTH - 2));
	assign rdata     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_q] <= wdata0;
		if (push_n == 2'd2)
			mem_q[wr_next] <= wdata1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QAW'(push_n);
			rd_q    <= rd_q + QAW'(pop);
			count_q <= count_q + (QAW+1)'(push_n) - (QAW+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("queue overflow");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue underflow");
	a_push_two: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 && !pop |=> count_q == $past(count_q) + (QAW+1)'(2))
		else $error("double push lost an entry");
`endif

endmodule

// File: hdl/source_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer
// C-style lexer: one byte or end marker in, newline/identifier/number/literal/
// at/symbol/end/error tokens out, with offset, length, line and first byte.
// ----------------------------------------------------------------------------
// One byte (or the end marker) is taken every cycle while byte_stall is low.
// A byte is registered, decoded against the scan state once the queue has
// room, and its tokens enter a four-entry queue whose head is offered on the
// token port. The output port hands out one token per cycle while
// token_stall is low, so a byte that closes one token and opens another (an
// identifier followed by a symbol, a lone carriage return followed by a byte,
// the end marker after an open token) yields two tokens to hand out; the byte
// port stalls while the queue holds more than two tokens. Offsets, lengths
// and line numbers saturate.
module source_text_tokenizer #(
	parameter int OFFSET_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [3:0]  token_kind,
	output logic [19:0] token_offset,
	output logic [19:0] token_length,
	output logic [19:0] token_line,
	output logic [7:0]  first_byte,
	output logic [1:0]  error_code,
	output logic        last_of_run
);
	import stt_pkg::*;

	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic       room;
	logic       fire;
	logic [1:0] push_n;
	entry_t     ent0;
	entry_t     ent1;
	entry_t     head;

	assign byte_stall = valid_s1 && !room;
	assign fire       = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
		end
	end

	stt_scan #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.is_end (kind_s1 == IN_END),
		.data   (byte_s1),
		.push_n (push_n),
		.ent0   (ent0),
		.ent1   (ent1)
	);

	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.wdata0    (ent0),
		.wdata1    (ent1),
		.pop       (token_valid && !token_stall),
		.not_empty (token_valid),
		.room      (room),
		.rdata     (head)
	);

	assign token_kind   = head.tok.kind;
	assign token_offset = head.tok.offset;
	assign token_length = head.tok.length;
	assign token_line   = head.tok.line;
	assign first_byte   = head.tok.first;
	assign error_code   = head.tok.err;
	assign last_of_run  = head.last;

endmodule
